// File: hw/rtl/morse_key_timing_capture_assert.svh
// Assertion macros shared by the key timing capture modules
`ifndef MORSE_KEY_TIMING_CAPTURE_ASSERT_SVH
`define MORSE_KEY_TIMING_CAPTURE_ASSERT_SVH

// Condition implies consequence in the same cycle
`define MKTC_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Condition implies consequence in the next cycle
`define MKTC_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/mktc_pkg.sv
// Shared types and constants for the key timing capture block
`timescale 1ns / 1ps
`default_nettype none

package mktc_pkg;

    localparam int MAX_SEQ_LEN_DEF = 64;
    localparam int OUT_DEPTH_DEF   = 4;

    localparam int SPAN_W      = 31;
    localparam int DUR_W       = 32;
    localparam int DEB_W       = 8;
    localparam int TICKS_W     = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_KEY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACE_END   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSURE     = 2'd3;

    localparam logic [DEB_W-1:0]   DEBOUNCE_RST  = 8'd15;
    localparam logic [TICKS_W-1:0] SPACE_END_RST = 16'd120;
    localparam logic [TICKS_W-1:0] CLOSURE_RST   = 16'd800;

    localparam logic [SPAN_W-1:0] SPAN_MAX = {SPAN_W{1'b1}};

    typedef enum logic [1:0] {
        KIND_ELEMENT = 2'd0,
        KIND_CLOSE   = 2'd1,
        KIND_OPEN    = 2'd2,
        KIND_END     = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                     kind;
        logic signed [DUR_W-1:0]   duration;
        logic                      last;
        logic                      key_down;
        logic                      latch_on;
    } result_t;

    typedef struct packed {
        logic    push0;
        logic    push1;
        result_t r0;
        result_t r1;
    } push_t;

    typedef struct packed {
        logic room2;
    } fifo_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/morse_key_timing_capture.sv
// Top level of the telegraph key timing capture block
//
// Usage: each item on the s_ channel is one 1 ms tick; s_tdata[0] carries the raw
// key level (1 = contact closed). Items on the m_ channel are timing elements and
// sequence markers: m_tuser is the kind, m_tdata[31:0] the signed span in ticks,
// m_tdata[32] the debounced key level, m_tdata[33] the circuit latch, and m_tlast
// ends a code sequence. The cfg_ channel writes the four registers at any time the
// block is idle; it is always ready.
// The results of an accepted tick are written into the result queue and reach m_ from its head.
// Throughput: one tick per cycle while s_tready is high. A tick gives at most two items
// (a space element followed by a circuit-open marker); the output port takes them one
// at a time, so a run of such ticks is limited by the output port.
// The result queue holds OUT_DEPTH items; s_tready is high while it has room for two.
// When the receiver stalls, the queue fills and s_tready drops; nothing is lost.
// Reset (aresetn low, synchronous) clears the key, latch, counters and the queue
// and restores register defaults: no inversion, debounce 15, space end 120,
// closure 800.
`timescale 1ns / 1ps
`default_nettype none

`include "morse_key_timing_capture_assert.svh"

module morse_key_timing_capture #(
    parameter int MAX_SEQ_LEN = mktc_pkg::MAX_SEQ_LEN_DEF,
    parameter int OUT_DEPTH   = mktc_pkg::OUT_DEPTH_DEF
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    input  wire  [mktc_pkg::IN_TDATA_W-1:0]     s_tdata,   // [0] key_sample
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    output logic [mktc_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [31:0] duration, [32] key_down,
                                                           // [33] latch_on
    output logic [1:0]                          m_tuser,   // [1:0] kind
    output logic                                m_tlast,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [mktc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [mktc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CW = $clog2(MAX_SEQ_LEN + 1);

    logic                            invert_reg;
    logic [mktc_pkg::DEB_W-1:0]      debounce_reg;
    logic [mktc_pkg::TICKS_W-1:0]    space_reg;
    logic [mktc_pkg::TICKS_W-1:0]    closure_reg;

    logic                            key_level_reg, key_level_next;
    logic                            latched_reg, latched_next;
    logic [mktc_pkg::SPAN_W-1:0]     elapsed_reg, elapsed_next;
    logic [mktc_pkg::SPAN_W-1:0]     saved_reg, saved_next;
    logic [mktc_pkg::DEB_W-1:0]      deb_reg, deb_next;
    logic [CW-1:0]                   cnt_reg, cnt_next;

    logic                            s_acc;
    logic                            level;
    logic [mktc_pkg::SPAN_W-1:0]     el_inc;
    logic signed [mktc_pkg::DUR_W-1:0] span_pos;
    mktc_pkg::push_t                 push;
    mktc_pkg::fifo_status_t          fifo_status;
    mktc_pkg::result_t               head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            invert_reg   <= 1'b0;
            debounce_reg <= mktc_pkg::DEBOUNCE_RST;
            space_reg    <= mktc_pkg::SPACE_END_RST;
            closure_reg  <= mktc_pkg::CLOSURE_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                mktc_pkg::CFG_INVERT_KEY: invert_reg   <= cfg_data[0];
                mktc_pkg::CFG_DEBOUNCE:   debounce_reg <= cfg_data[mktc_pkg::DEB_W-1:0];
                mktc_pkg::CFG_SPACE_END:  space_reg    <= cfg_data;
                mktc_pkg::CFG_CLOSURE:    closure_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s_tready = fifo_status.room2;
    assign s_acc    = s_tvalid && s_tready;
    assign level    = s_tdata[0] ^ invert_reg;
    assign el_inc   = (elapsed_reg == mktc_pkg::SPAN_MAX) ? elapsed_reg : elapsed_reg + 1'b1;
    assign span_pos = $signed({1'b0, saved_reg});

    always_comb begin
        key_level_next = key_level_reg;
        latched_next   = latched_reg;
        elapsed_next   = elapsed_reg;
        saved_next     = saved_reg;
        deb_next       = deb_reg;
        cnt_next       = cnt_reg;
        push.push0     = 1'b0;
        push.push1     = 1'b0;
        push.r0.kind     = mktc_pkg::KIND_ELEMENT;
        push.r0.duration = '0;
        push.r0.last     = 1'b0;
        push.r1.kind     = mktc_pkg::KIND_OPEN;
        push.r1.duration = '0;
        push.r1.last     = 1'b1;

        if (s_acc) begin
            elapsed_next = el_inc;
            if (deb_reg != '0) begin
                deb_next = deb_reg - 1'b1;
                if (deb_reg == mktc_pkg::DEB_W'(1)) begin
                    push.push0 = 1'b1;
                    if (key_level_reg) begin
                        cnt_next         = cnt_reg + 1'b1;
                        push.r0.duration = -span_pos;
                    end else if (latched_reg) begin
                        latched_next     = 1'b0;
                        cnt_next         = '0;
                        push.r0.duration = -span_pos;
                        push.push1       = 1'b1;
                    end else begin
                        cnt_next         = cnt_reg + 1'b1;
                        push.r0.duration = span_pos;
                    end
                    if (!push.push1 && (cnt_next >= CW'(MAX_SEQ_LEN))) begin
                        push.r0.last = 1'b1;
                        cnt_next     = '0;
                    end
                end
            end else if (level != key_level_reg) begin
                key_level_next = level;
                saved_next     = el_inc;
                elapsed_next   = '0;
                deb_next       = (debounce_reg != '0) ? debounce_reg : mktc_pkg::DEB_W'(1);
            end else if (!key_level_reg && (cnt_reg != '0)
                         && (el_inc > mktc_pkg::SPAN_W'(space_reg))) begin
                cnt_next     = '0;
                push.push0   = 1'b1;
                push.r0.kind = mktc_pkg::KIND_END;
                push.r0.last = 1'b1;
            end else if (key_level_reg && !latched_reg
                         && (el_inc > mktc_pkg::SPAN_W'(closure_reg))) begin
                latched_next = 1'b1;
                cnt_next     = '0;
                push.push0   = 1'b1;
                push.r0.kind = mktc_pkg::KIND_CLOSE;
                push.r0.last = 1'b1;
            end else if (cnt_reg >= CW'(MAX_SEQ_LEN)) begin
                cnt_next     = '0;
                push.push0   = 1'b1;
                push.r0.kind = mktc_pkg::KIND_END;
                push.r0.last = 1'b1;
            end
        end

        push.r0.key_down = key_level_next;
        push.r0.latch_on = latched_next;
        push.r1.key_down = key_level_next;
        push.r1.latch_on = latched_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_level_reg <= 1'b0;
            latched_reg   <= 1'b0;
            elapsed_reg   <= '0;
            saved_reg     <= '0;
            deb_reg       <= '0;
            cnt_reg       <= '0;
        end else begin
            key_level_reg <= key_level_next;
            latched_reg   <= latched_next;
            elapsed_reg   <= elapsed_next;
            saved_reg     <= saved_next;
            deb_reg       <= deb_next;
            cnt_reg       <= cnt_next;
        end
    end

    mktc_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .status    (fifo_status),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (head)
    );

    assign m_tdata = {{(mktc_pkg::OUT_TDATA_W - mktc_pkg::DUR_W - 2){1'b0}},
                      head.latch_on, head.key_down, head.duration};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

    `MKTC_ASSERT_IMP(a_cnt_bound, aclk, aresetn, 1'b1, cnt_reg <= CW'(MAX_SEQ_LEN),
        "element count beyond sequence limit")
    `MKTC_ASSERT_NXT(a_key_hold, aclk, aresetn, s_acc && (deb_reg != '0),
        $stable(key_level_reg), "key level changed while debouncing")
    `MKTC_ASSERT_IMP(a_pair_open, aclk, aresetn, push.push1,
        (push.r1.kind == mktc_pkg::KIND_OPEN) && !latched_next, "second item not an open marker")
    `MKTC_ASSERT_IMP(a_quiet_debounce, aclk, aresetn, deb_reg > mktc_pkg::DEB_W'(1),
        !push.push0, "item produced during debounce")

endmodule

`default_nettype wire

// File: hw/rtl/mktc_out_fifo.sv
// Result queue taking up to two items per cycle and giving one when the output is ready
`timescale 1ns / 1ps
`default_nettype none

`include "morse_key_timing_capture_assert.svh"

module mktc_out_fifo #(
    parameter int DEPTH = mktc_pkg::OUT_DEPTH_DEF
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  mktc_pkg::push_t       push,
    output mktc_pkg::fifo_status_t status,
    output logic                  out_valid,
    input  wire                   out_ready,
    output mktc_pkg::result_t     out_item
);

    localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    mktc_pkg::result_t mem_reg [DEPTH];
    logic [IW-1:0]   wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next, wr1_ptr;
    logic [CNTW-1:0] count_reg, count_next;
    logic            pop;

    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] p);
        logic [IW-1:0] r;
        r = (p == IW'(DEPTH - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    always_comb begin
        pop        = out_valid && out_ready;
        wr1_ptr    = wrap_inc(wr_ptr_reg);
        wr_ptr_next = wr_ptr_reg;
        if (push.push1) begin
            wr_ptr_next = wrap_inc(wr1_ptr);
        end else if (push.push0) begin
            wr_ptr_next = wr1_ptr;
        end
        rd_ptr_next = pop ? wrap_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNTW'(push.push0) + CNTW'(push.push1) - CNTW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.push0) begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.push1) begin
            mem_reg[wr1_ptr] <= push.r1;
        end
    end

    assign out_valid    = (count_reg != '0);
    assign out_item     = mem_reg[rd_ptr_reg];
    assign status.room2 = (count_reg <= CNTW'(DEPTH - 2));

    `MKTC_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNTW'(DEPTH),
        "queue count beyond depth")
    `MKTC_ASSERT_IMP(a_no_overflow, aclk, aresetn, push.push0,
        count_reg <= CNTW'(DEPTH - 2), "queue written without room")
    `MKTC_ASSERT_IMP(a_pair_order, aclk, aresetn, push.push1, push.push0,
        "second item pushed without first")

endmodule

`default_nettype wire
